>>> rtl/core/swa_pkg.sv
// ============================================================================
// swa_pkg
// Shared constants and helpers for the sliding window average core.
// ============================================================================
package swa_pkg;

  // Width of the window length register and its value after reset.
  localparam int unsigned WINDOW_BITS = 5;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 5'd10;

  // Headroom bits of the running sum above the sample width.
  localparam int unsigned SUM_EXTRA = 5;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_WINDOW_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // Width that holds both the window register and the ring depth itself.
  function automatic int unsigned win_width(input int unsigned max_window);
    int unsigned w;
    w = $clog2(max_window + 1);
    if (w < WINDOW_BITS) begin
      w = WINDOW_BITS;
    end
    return w;
  endfunction

endpackage

>>> rtl/core/swa_window.sv
// ============================================================================
// swa_window
// Sample ring, write pointer, fill count and running sum. A started word is
// read against the ring into registers, then folded into the sum, which
// then pulses done.
// ============================================================================
module swa_window #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [SAMPLE_BITS-1:0]                    sample_i,
  input  logic [swa_pkg::win_width(MAX_WINDOW)-1:0] win_i,
  output logic [SAMPLE_BITS+swa_pkg::SUM_EXTRA-1:0] sum_o,
  output logic                                      done_o
);

  localparam int unsigned SumW = SAMPLE_BITS + swa_pkg::SUM_EXTRA;
  localparam int unsigned WinW = swa_pkg::win_width(MAX_WINDOW);
  localparam int unsigned IdxW = $clog2(MAX_WINDOW);
  localparam int unsigned AddrW = ((WinW > IdxW) ? WinW : IdxW) + 1;
  localparam int unsigned FillW = swa_pkg::WINDOW_BITS;

  logic [SAMPLE_BITS-1:0]  ring_q [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]  old_q;
  logic [SAMPLE_BITS-1:0]  samp_q;
  logic                    pend_q;
  logic                    done_q;
  logic [IdxW-1:0]         wp_q, wp_d;
  logic [FillW-1:0]        fill_q, fill_d;
  logic [SumW-1:0]         sum_q, sum_d;
  logic [AddrW-1:0]        wp_ext, win_ext, diff;
  logic [IdxW-1:0]         old_addr;
  logic                    filling;

  // Ring position that lies the window length behind the write pointer.
  always_comb begin
    wp_ext  = AddrW'(wp_q);
    win_ext = AddrW'(win_i);
    diff    = wp_ext - win_ext;
    if (wp_ext < win_ext) begin
      diff = diff + AddrW'(MAX_WINDOW);
    end
    old_addr = diff[IdxW-1:0];
  end

  // Sum update: add the new sample, drop the oldest once the window is full.
  always_comb begin
    filling = (AddrW'(fill_q) < win_ext);
    sum_d   = sum_q + {{swa_pkg::SUM_EXTRA{samp_q[SAMPLE_BITS-1]}}, samp_q};
    fill_d  = fill_q;
    if (filling) begin
      fill_d = fill_q + FillW'(1);
    end else begin
      sum_d = sum_d - {{swa_pkg::SUM_EXTRA{old_q[SAMPLE_BITS-1]}}, old_q};
    end
    if (wp_q == IdxW'(MAX_WINDOW - 1)) begin
      wp_d = '0;
    end else begin
      wp_d = wp_q + IdxW'(1);
    end
  end

  // Ring memory: registered read at start, write during the update cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      old_q  <= ring_q[old_addr];
      samp_q <= sample_i;
    end
    if (pend_q) begin
      ring_q[wp_q] <= samp_q;
    end
  end

  // Control state and running sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      pend_q <= start_i;
      done_q <= pend_q;
      if (pend_q) begin
        wp_q   <= wp_d;
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
    end
  end

  assign sum_o  = sum_q;
  assign done_o = done_q;

`ifndef SYNTH
  // The write pointer never leaves the ring, also for depths that are not
  // a power of two.
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= IdxW'(MAX_WINDOW - 1))
    else $error("write pointer beyond ring depth");
`endif

endmodule

>>> rtl/core/swa_serdiv.sv
// ============================================================================
// swa_serdiv
// Bit-serial restoring divider. The magnitude of the running sum shifts out
// one bit per cycle against a narrow remainder while quotient bits shift in,
// then the signed quotient is saturated to the sample width.
// ============================================================================
module swa_serdiv #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [SAMPLE_BITS+swa_pkg::SUM_EXTRA-1:0] sum_i,
  input  logic [swa_pkg::win_width(MAX_WINDOW)-1:0] win_i,
  output logic [SAMPLE_BITS-1:0]                    quot_o,
  output logic                                      done_o
);

  localparam int unsigned SumW = SAMPLE_BITS + swa_pkg::SUM_EXTRA;
  localparam int unsigned WinW = swa_pkg::win_width(MAX_WINDOW);
  localparam int unsigned RemW = WinW + 1;
  localparam int unsigned CntW = $clog2(SumW + 1);
  localparam logic [SumW-1:0] MagPos =
    {{(SumW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SumW-1:0] MagNeg = MagPos + SumW'(1);
  localparam logic [SAMPLE_BITS-1:0] OutLo = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic [SumW-1:0]  dq_q;
  logic [RemW-1:0]  rem_q;
  logic [RemW-1:0]  trial, rem_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             neg_q;
  logic             ge;
  logic [SumW-1:0]  mag;

  // Magnitude of the dividend at load.
  assign mag = sum_i[SumW-1] ? (~sum_i + SumW'(1)) : sum_i;

  // One restoring step: trial subtract of the window from the remainder.
  always_comb begin
    trial = {rem_q[RemW-2:0], dq_q[SumW-1]};
    ge    = (trial >= RemW'(win_i));
    rem_d = ge ? (trial - RemW'(win_i)) : trial;
  end

  // Iteration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift registers for dividend, quotient and remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= mag;
      rem_q <= '0;
      neg_q <= sum_i[SumW-1];
    end else if (busy_q) begin
      dq_q  <= {dq_q[SumW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  // Restore the sign and saturate to the sample range.
  always_comb begin
    if (neg_q) begin
      if (dq_q > MagNeg) begin
        quot_o = OutLo;
      end else begin
        quot_o = ~dq_q[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
      end
    end else begin
      if (dq_q > MagPos) begin
        quot_o = MagPos[SAMPLE_BITS-1:0];
      end else begin
        quot_o = dq_q[SAMPLE_BITS-1:0];
      end
    end
  end

  assign done_o = done_q;

`ifndef SYNTH
  // A new division is never started over one still in progress.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  // The remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < RemW'(win_i)))
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> rtl/core/sliding_window_average_core.sv
// ============================================================================
// sliding_window_average_core
// Running mean of the last window samples, Q16.8, truncated toward zero.
// ============================================================================
// An accepted sample passes the window update, then the bit-serial divider,
// which takes one quotient bit per cycle over the SAMPLE_BITS+5-bit sum, and
// then the output register. No new sample is taken until the last average
// has been loaded into the output register.
// Reset: asynchronous, active low; clears sum, fill count, pointer and
// handshake state and sets the window length to 10. The ring is not cleared.
module sliding_window_average_core #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: window length.
  input  logic                              cfg_we_i,
  input  logic [swa_pkg::WINDOW_BITS-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata   // [SAMPLE_BITS-1:0] average
);

  localparam int unsigned DataW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned SumW  = SAMPLE_BITS + swa_pkg::SUM_EXTRA;
  localparam int unsigned WinW  = swa_pkg::win_width(MAX_WINDOW);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StBusy = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [swa_pkg::WINDOW_BITS-1:0] win_q;
  logic [WinW-1:0]                 win_eff;
  logic                            in_acc;
  logic                            out_free;
  logic                            out_load;
  logic                            out_valid_q;
  logic [SAMPLE_BITS-1:0]          out_data_q;
  logic [SumW-1:0]                 sum;
  logic                            upd_done;
  logic [SAMPLE_BITS-1:0]          quot;
  logic                            div_done;

  // Window length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= swa_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Effective window: zero acts as one, anything above the ring depth is
  // clamped to the depth.
  always_comb begin
    win_eff = WinW'(win_q);
    if (win_q == '0) begin
      win_eff = WinW'(1);
    end else if (win_eff > WinW'(MAX_WINDOW)) begin
      win_eff = WinW'(MAX_WINDOW);
    end
  end

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer: one sample in flight at a time.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StBusy;
        end
      end
      StBusy: begin
        if (div_done) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = StIdle;
          end else begin
            state_d = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= quot;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'(out_data_q);

  swa_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .win_i    (win_eff),
    .sum_o    (sum),
    .done_o   (upd_done)
  );

  swa_serdiv #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_serdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (upd_done),
    .sum_i   (sum),
    .win_i   (win_eff),
    .quot_o  (quot),
    .done_o  (div_done)
  );

`ifndef SYNTH
  // After a sample is taken, no further sample is taken in the next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second sample accepted while one is in flight");

  // A finished division only arrives while the sequencer waits for it.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StBusy))
    else $error("division finished outside the busy state");
`endif

endmodule

>>> tb/sliding_window_average_checker.sv
// ============================================================================
// sliding_window_average_checker
// Watches the configuration port and both streams of the moving average core,
// predicts every average word from the accepted samples and compares it with
// the word that leaves the block, in order.
// ============================================================================
module sliding_window_average_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [swa_pkg::WINDOW_BITS-1:0]   cfg_wdata_i,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [swa_pkg::SAMPLE_BITS_DEF-1:0] s_tdata_i,  // [23:0] sample
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [swa_pkg::SAMPLE_BITS_DEF-1:0] m_tdata_i,  // [23:0] average
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                averages_seen_o
);

  localparam int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + swa_pkg::SUM_EXTRA;
  localparam int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF;
  localparam longint      AVG_HI      = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint      AVG_LO      = -AVG_HI - 1;

  // Shadow copy of the block's state and its window register.
  logic [swa_pkg::WINDOW_BITS-1:0] window_len = swa_pkg::WINDOW_RESET;
  logic signed [SAMPLE_BITS-1:0]   past_samples [MAX_WINDOW];
  logic signed [SUM_BITS-1:0]      window_sum = '0;
  int unsigned                     write_slot = 0;
  int unsigned                     samples_counted = 0;

  // Averages still owed by the block, oldest first.
  logic [SAMPLE_BITS-1:0]          expected_averages [$];
  logic [SAMPLE_BITS-1:0]          owed_average;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    averages_seen_o = 0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      past_samples[i] = '0;
    end
  end

  // One line per mismatch, and the count handed to the top.
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // Moves the shadow state on by one sample and returns the average word.
  function automatic logic [SAMPLE_BITS-1:0] next_average(input logic [SAMPLE_BITS-1:0] word);
    longint      smp;
    longint      total;
    longint      quo;
    int unsigned span;
    int unsigned leaving;
    smp = longint'($signed(word));
    // A zero window acts as one, anything above the ring depth as the depth.
    if (window_len == 0) begin
      span = 1;
    end else if (window_len > MAX_WINDOW) begin
      span = MAX_WINDOW;
    end else begin
      span = window_len;
    end
    total = longint'(window_sum) + smp;
    // While the window is still filling the sum only grows.
    if (samples_counted < span) begin
      samples_counted++;
    end else begin
      leaving = (write_slot + MAX_WINDOW - span) % MAX_WINDOW;
      total -= longint'(past_samples[leaving]);
    end
    window_sum = total[SUM_BITS-1:0];
    past_samples[write_slot] = word;
    write_slot = (write_slot + 1) % MAX_WINDOW;
    // Division truncates toward zero; the quotient saturates to the word range.
    quo = longint'(window_sum) / longint'(span);
    if (quo > AVG_HI) begin
      quo = AVG_HI;
    end
    if (quo < AVG_LO) begin
      quo = AVG_LO;
    end
    return quo[SAMPLE_BITS-1:0];
  endfunction

  // Follow the register, predict on each accepted sample, check each average.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len      = swa_pkg::WINDOW_RESET;
      window_sum      = '0;
      write_slot      = 0;
      samples_counted = 0;
      expected_averages.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        window_len = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_averages.push_back(next_average(s_tdata_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        averages_seen_o++;
        if (expected_averages.size() == 0) begin
          report_mismatch($sformatf("average word 0x%06h with no sample behind it",
                                    m_tdata_i));
        end else begin
          owed_average = expected_averages.pop_front();
          if (m_tdata_i !== owed_average) begin
            report_mismatch($sformatf("average 0x%06h, expected 0x%06h",
                                      m_tdata_i, owed_average));
          end
        end
      end
      pending_o <= expected_averages.size();
    end
  end

endmodule

>>> tb/tb.sv
// ============================================================================
// tb
// Stimulus and verdict for the sliding window average core: directed samples
// at the range limits and window extremes, then random phases with idle and
// stall patterns, a long output hold and pauses until the block drains.
// ============================================================================
module tb;

  localparam int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF;
  // Cycles allowed after the last word for the block to settle.
  localparam int unsigned SETTLE      = SAMPLE_BITS + 16;
  localparam int unsigned PHASES      = 8;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [swa_pkg::WINDOW_BITS-1:0] cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [SAMPLE_BITS-1:0]          s_axis_tdata  = '0;  // [23:0] sample
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [SAMPLE_BITS-1:0]          m_axis_tdata;        // [23:0] average

  int  fail_count;
  int  pending;
  int  averages_seen;

  int  source_idle_pct = 0;
  int  sink_stall_pct  = 0;
  logic sink_hold      = 1'b0;
  int  samples_sent    = 0;
  int  windows_written = 0;

  // Clock with a period of four time units.
  always #2 clk_i = ~clk_i;

  sliding_window_average_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sliding_window_average_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .averages_seen_o (averages_seen)
  );

  // Output side: random stalls, or a solid hold while one is requested.
  always @(posedge clk_i) begin
    if (sink_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Offers one sample word, with random idle cycles ahead of it.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] word);
    while ($urandom_range(0, 99) < source_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    samples_sent++;
  endtask

  // Stops offering and waits until every average has come out. It waits
  // for a clock edge first so that the count already holds the last accepted word.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes the window length once the block is idle.
  task automatic write_window(input logic [swa_pkg::WINDOW_BITS-1:0] len);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    windows_written++;
  endtask

  // Random sample biased toward the limits and toward small magnitudes.
  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    logic [SAMPLE_BITS-1:0] word;
    case ($urandom_range(0, 7))
      0: begin
        word = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      1: begin
        word = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end
      2: begin
        word = SAMPLE_BITS'($urandom_range(0, 511) - 256);
      end
      3: begin
        word = {1'b0, {(SAMPLE_BITS-1){1'b1}}} - SAMPLE_BITS'($urandom_range(0, 15));
      end
      4: begin
        word = {1'b1, {(SAMPLE_BITS-1){1'b0}}} + SAMPLE_BITS'($urandom_range(0, 15));
      end
      default: begin
        word = SAMPLE_BITS'($urandom());
      end
    endcase
    return word;
  endfunction

  // Main stimulus.
  initial begin
    int win_plan [PHASES];
    int src_plan [4];
    int sink_plan [4];
    int phase_len;
    int pause_at;
    win_plan  = '{16, 3, 1, 10, 31, 0, 7, 2};
    src_plan  = '{0, 88, 0, 8};
    sink_plan = '{0, 0, 88, 8};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window of ten: range limits, ones, zero and alternating patterns,
    // running past the fill so that old samples start to leave.
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);
    push_sample(24'hFFFFFF);
    push_sample(24'h000001);
    push_sample(24'h000000);
    push_sample(24'h7FFFFF);
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);
    push_sample(24'h555555);
    push_sample(24'hAAAAAA);
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);

    // A zero window acts as one; the old sum offset drives saturation.
    write_window(5'd0);
    push_sample(24'hFFFFFF);
    push_sample(24'h800000);
    push_sample(24'h7FFFFF);

    // All ones acts as the full ring; the sum grows while the window refills.
    write_window(5'd31);
    push_sample(24'h7FFFFF);
    push_sample(24'h7FFFFF);
    push_sample(24'h7FFFFF);
    push_sample(24'h7FFFFF);

    // Just above the ring depth, then back down to a single sample.
    write_window(5'd17);
    push_sample(24'h7FFFFF);
    write_window(5'd1);
    push_sample(24'h7FFFFF);
    push_sample(24'h800000);
    push_sample(24'h000001);

    // Random phases, each with its own window and idle pattern.
    for (int p = 0; p < PHASES; p++) begin
      write_window(5'(win_plan[p]));
      source_idle_pct <= src_plan[p % 4];
      sink_stall_pct  <= sink_plan[p % 4];
      phase_len = $urandom_range(45, 52);
      pause_at  = $urandom_range(10, phase_len - 10);
      // First phase: hold the output off long enough to back up the input.
      if (p == 0) begin
        fork
          begin
            @(posedge clk_i);
            sink_hold <= 1'b1;
            repeat (400) @(posedge clk_i);
            sink_hold <= 1'b0;
          end
        join_none
      end
      for (int i = 0; i < phase_len; i++) begin
        // Mid-phase the sender waits for every average before going on.
        if (i == pause_at) begin
          drain_block();
        end
        push_sample(random_sample());
      end
    end

    drain_block();
    $display("tb: %0d samples sent, %0d averages checked, %0d window writes",
             samples_sent, averages_seen, windows_written);
    $display("tb: windows 0, 1, 16, 17 and 31, saturation, idle and stall phases, long hold");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/swa_pkg.sv
rtl/core/swa_window.sv
rtl/core/swa_serdiv.sv
rtl/core/sliding_window_average_core.sv
tb/sliding_window_average_checker.sv
tb/tb.sv
